// File: rtl/hcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, register indexes and window offset helpers for the Harris
// corner detector.
// ----------------------------------------------------------------------------
package hcd_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] pixel;
    } pix_t;

    typedef struct packed {
        logic        corner;
        logic [10:0] col;
        logic [11:0] row;
        logic        last;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_N_SEL,
        ST_PC_READ,
        ST_PC_CWAIT,
        ST_PC_TAP,
        ST_PC_TWAIT,
        ST_PC_MUL,
        ST_PC_END,
        ST_M_NEXT,
        ST_R_MUL1,
        ST_R_MUL2,
        ST_R_MUL3,
        ST_R_FIN,
        ST_R_SUB,
        ST_R_END,
        ST_OUT
    } state_t;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [7:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [7:0] REG_FRAME_HEIGHT = 8'd1;
    localparam logic [7:0] REG_THRESHOLD    = 8'd2;
    localparam logic [7:0] REG_K_COEFF      = 8'd3;

    localparam logic [11:0] WIDTH_RESET     = 12'd640;
    localparam logic [11:0] HEIGHT_RESET    = 12'd480;
    localparam logic [39:0] THRESHOLD_RESET = 40'd1000000;
    localparam logic [15:0] K_RESET         = 16'd3932;

    localparam logic [3:0] TAP_CENTER = 4'd4;
    localparam logic [3:0] TAP_LAST   = 4'd8;

    // row offset of 3x3 tap index, raster order
    function automatic logic signed [1:0] off_dy(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd0, 4'd1, 4'd2: d = -2'sd1;
            4'd3, 4'd4, 4'd5: d = 2'sd0;
            4'd6, 4'd7, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] off_dx(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd0, 4'd3, 4'd6: d = -2'sd1;
            4'd1, 4'd4, 4'd7: d = 2'sd0;
            4'd2, 4'd5, 4'd8: d = 2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    // log2 of the 1-2-1 x 1-2-1 weight at a tap
    function automatic logic [1:0] tap_shift(input logic [3:0] idx);
        logic [1:0] s;
        s = 2'((off_dy(idx) == 2'sd0) ? 1 : 0) + 2'((off_dx(idx) == 2'sd0) ? 1 : 0);
        return s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/harris_corner_detector_unit.sv
`default_nettype none
// A due result needs one response evaluation when the centre is not above
//   threshold, and up to nine when it is a candidate; a pixel that releases
//   no result goes from ST_CHECK straight back to ST_IDLE.
// The pixel memory has a single read port: every tap of every gradient is
//   fetched one at a time, through a read state and then a wait state.
// Reset: positions cleared, registers to defaults; pixel memory is not cleared.
// ----------------------------------------------------------------------------
// harris_corner_detector_unit
// Streaming 3x3 Harris corner detector: pixels are stored in an 8-row line
// memory and each due position is evaluated by a read-modify sequencer.
// ----------------------------------------------------------------------------
module harris_corner_detector_unit #(
    parameter int MAX_WIDTH   = 2048,
    parameter int K_FRAC_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pix_valid,
    output logic               pix_ready,
    input  wire hcd_pkg::pix_t pix_data,
    output logic               res_valid,
    input  wire logic          res_ready,
    output hcd_pkg::res_t      res_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [39:0]   cfg_data
);
    import hcd_pkg::*;

    localparam int XW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int GW    = XW + 1;
    localparam int CXW   = XW + 2;
    localparam int YW    = 14;
    localparam int PW    = XW + 13;
    localparam int DEPTH = 8 << XW;
    localparam int AW    = XW + 3;
    localparam int RW    = (68 - K_FRAC_BITS > 52) ? 68 - K_FRAC_BITS : 52;
    localparam int FW    = K_FRAC_BITS + RW;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;

    state_t state_reg, state_next;
    logic [11:0] width_cfg_reg, width_cfg_next;
    logic [11:0] height_cfg_reg, height_cfg_next;
    logic [39:0] thr_reg, thr_next;
    logic [15:0] k_reg, k_next;
    logic [PW-1:0] in_pos_reg, in_pos_next, out_pos_reg, out_pos_next;
    logic [XW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [11:0]   in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [3:0] ni_reg, ni_next, mi_reg, mi_next, ti_reg, ti_next;
    logic first_reg, first_next, ctx_reg, ctx_next, corner_reg, corner_next;
    logic signed [YW-1:0]  qy_reg, qy_next;
    logic signed [CXW-1:0] qx_reg, qx_next;
    logic [7:0] cpix_reg, cpix_next;
    logic signed [10:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [19:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [20:0] pc_reg, pc_next;
    logic [19:0] cena_reg, cena_next, cenb_reg, cenb_next;
    logic signed [20:0] cenc_reg, cenc_next;
    logic [23:0] acca_reg, acca_next, accb_reg, accb_next;
    logic signed [24:0] accc_reg, accc_next;
    logic [47:0] ab_reg, ab_next, cc_reg, cc_next;
    logic [24:0] s_reg, s_next;
    logic signed [49:0] det_reg, det_next;
    logic [49:0] t_reg, t_next;
    logic [41:0] ph_reg, ph_next;
    logic [39:0] pl_reg, pl_next;
    logic [RW-1:0] kt_reg, kt_next;
    logic signed [RW-1:0] r_reg, r_next, r0_reg, r0_next;

    logic [GW-1:0] w_use;
    logic [11:0]   h_use;
    logic [PW-1:0] total;
    logic [PW:0]   due_level;
    logic          due, res_last;
    logic signed [YW-1:0]  n_y, m_y, t_y;
    logic signed [CXW-1:0] n_x, m_x, t_x;
    logic n_in, m_in, t_in;
    logic [7:0] tap_pix;
    logic signed [10:0] tap_val;
    logic [19:0] src_a, src_b;
    logic signed [20:0] src_c;
    logic [1:0] sh;
    logic signed [21:0] sq_x, sq_y, xy;
    logic signed [49:0] c_sq;
    logic [FW-1:0] kt_full;
    logic signed [RW-1:0] level_s;
    logic pix_acc, res_acc;

    always_comb
    begin
        if (width_cfg_reg < 12'd3)
            w_use = GW'(3);
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
            w_use = GW'(MAX_WIDTH);
        else
            w_use = GW'(width_cfg_reg);
        if (height_cfg_reg < 12'd3)
            h_use = 12'd3;
        else if (height_cfg_reg == 12'hFFF)
            h_use = 12'd4095;
        else
            h_use = height_cfg_reg;
    end

    assign total     = PW'(w_use) * PW'(h_use);
    assign due_level = (PW + 1)'(out_pos_reg) + (PW + 1)'(w_use) * (PW + 1)'(3)
                       + (PW + 1)'(4);
    assign due       = (out_pos_reg < total)
                       && ((in_pos_reg == total) || ((PW + 1)'(in_pos_reg) >= due_level));
    assign res_last  = ((out_pos_reg + PW'(1)) == total);

    assign n_y = YW'($signed({2'b00, out_row_reg})) + YW'(off_dy(ni_reg));
    assign n_x = CXW'($signed({2'b00, out_col_reg})) + CXW'(off_dx(ni_reg));
    assign m_y = n_y + YW'(off_dy(mi_reg));
    assign m_x = n_x + CXW'(off_dx(mi_reg));
    assign t_y = qy_reg + YW'(off_dy(ti_reg));
    assign t_x = qx_reg + CXW'(off_dx(ti_reg));
    assign n_in = !n_y[YW-1] && (n_y < $signed({2'b00, h_use}))
                  && !n_x[CXW-1] && (n_x < $signed({1'b0, w_use}));
    assign m_in = !m_y[YW-1] && (m_y < $signed({2'b00, h_use}))
                  && !m_x[CXW-1] && (m_x < $signed({1'b0, w_use}));
    assign t_in = !t_y[YW-1] && (t_y < $signed({2'b00, h_use}))
                  && !t_x[CXW-1] && (t_x < $signed({1'b0, w_use}));

    assign tap_pix = (state_reg == ST_PC_TWAIT) ? rdata_reg : cpix_reg;
    assign tap_val = $signed({3'b000, tap_pix});
    assign src_a   = (state_reg == ST_PC_END) ? pa_reg : cena_reg;
    assign src_b   = (state_reg == ST_PC_END) ? pb_reg : cenb_reg;
    assign src_c   = (state_reg == ST_PC_END) ? pc_reg : cenc_reg;
    assign sh      = tap_shift(mi_reg);
    assign sq_x    = gx_reg * gx_reg;
    assign sq_y    = gy_reg * gy_reg;
    assign xy      = gx_reg * gy_reg;
    assign c_sq    = accc_reg * accc_reg;
    assign kt_full = (FW'(ph_reg) << 24) + FW'(pl_reg);
    assign level_s = $signed(RW'({thr_reg, 8'hFF}));

    assign pix_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    // register writes only between pixel transactions, with nothing in flight
    assign cfg_ready = (state_reg == ST_IDLE) && !pix_valid;
    assign pix_acc   = pix_valid && pix_ready;
    assign res_acc   = res_valid && res_ready;

    assign res_data.corner = corner_reg;
    assign res_data.col    = 11'(out_col_reg);
    assign res_data.row    = out_row_reg;
    assign res_data.last   = res_last;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= pix_data.pixel;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        thr_next        = thr_reg;
        k_next          = k_reg;
        in_pos_next     = in_pos_reg;
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        out_pos_next    = out_pos_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        ni_next         = ni_reg;
        mi_next         = mi_reg;
        ti_next         = ti_reg;
        first_next      = first_reg;
        ctx_next        = ctx_reg;
        corner_next     = corner_reg;
        qy_next         = qy_reg;
        qx_next         = qx_reg;
        cpix_next       = cpix_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        pc_next         = pc_reg;
        cena_next       = cena_reg;
        cenb_next       = cenb_reg;
        cenc_next       = cenc_reg;
        acca_next       = acca_reg;
        accb_next       = accb_reg;
        accc_next       = accc_reg;
        ab_next         = ab_reg;
        cc_next         = cc_reg;
        s_next          = s_reg;
        det_next        = det_reg;
        t_next          = t_reg;
        ph_next         = ph_reg;
        pl_next         = pl_reg;
        kt_next         = kt_reg;
        r_next          = r_reg;
        r0_next         = r0_reg;
        mem_we          = 1'b0;
        mem_waddr       = {in_row_reg[2:0], in_col_reg};
        mem_re          = 1'b0;
        mem_raddr       = {qy_reg[2:0], qx_reg[XW-1:0]};

        case (state_reg)
            ST_IDLE:
            begin
                if (pix_acc)
                begin
                    if ((pix_data.mode == MODE_PIXEL) && (in_pos_reg < total))
                    begin
                        mem_we      = 1'b1;
                        in_pos_next = in_pos_reg + PW'(1);
                        if (GW'(in_col_reg) == w_use - GW'(1))
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + 12'd1;
                        end
                        else
                            in_col_next = in_col_reg + XW'(1);
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (due)
                begin
                    ni_next    = TAP_CENTER;
                    first_next = 1'b1;
                    state_next = ST_N_SEL;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_N_SEL:
            begin
                if (!first_reg && ((ni_reg == TAP_CENTER) || !n_in))
                begin
                    if (ni_reg == TAP_LAST)
                        state_next = ST_OUT;
                    else
                        ni_next = ni_reg + 4'd1;
                end
                else
                begin
                    qy_next    = n_y;
                    qx_next    = n_x;
                    ctx_next   = 1'b0;
                    state_next = ST_PC_READ;
                end
            end
            ST_PC_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_PC_CWAIT;
            end
            ST_PC_CWAIT:
            begin
                cpix_next  = rdata_reg;
                gx_next    = '0;
                gy_next    = '0;
                ti_next    = '0;
                state_next = ST_PC_TAP;
            end
            ST_PC_TAP, ST_PC_TWAIT:
            begin
                if ((state_reg == ST_PC_TAP) && t_in && (ti_reg != TAP_CENTER))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {t_y[2:0], t_x[XW-1:0]};
                    state_next = ST_PC_TWAIT;
                end
                else
                begin
                    if (off_dx(ti_reg) == 2'sd1)
                        gx_next = gx_reg + tap_val;
                    else if (off_dx(ti_reg) == -2'sd1)
                        gx_next = gx_reg - tap_val;
                    if (off_dy(ti_reg) == 2'sd1)
                        gy_next = gy_reg + tap_val;
                    else if (off_dy(ti_reg) == -2'sd1)
                        gy_next = gy_reg - tap_val;
                    if (ti_reg == TAP_LAST)
                        state_next = ST_PC_MUL;
                    else
                    begin
                        ti_next    = ti_reg + 4'd1;
                        state_next = ST_PC_TAP;
                    end
                end
            end
            ST_PC_MUL:
            begin
                pa_next    = sq_x[19:0];
                pb_next    = sq_y[19:0];
                pc_next    = xy[20:0];
                state_next = ST_PC_END;
            end
            ST_PC_END, ST_M_NEXT:
            begin
                if ((state_reg == ST_PC_END) && !ctx_reg)
                begin
                    cena_next  = pa_reg;
                    cenb_next  = pb_reg;
                    cenc_next  = pc_reg;
                    acca_next  = '0;
                    accb_next  = '0;
                    accc_next  = '0;
                    mi_next    = '0;
                    state_next = ST_M_NEXT;
                end
                else if ((state_reg == ST_M_NEXT) && m_in && (mi_reg != TAP_CENTER))
                begin
                    qy_next    = m_y;
                    qx_next    = m_x;
                    ctx_next   = 1'b1;
                    state_next = ST_PC_READ;
                end
                else
                begin
                    acca_next = acca_reg + (24'(src_a) << sh);
                    accb_next = accb_reg + (24'(src_b) << sh);
                    accc_next = accc_reg + (25'(src_c) <<< sh);
                    if (mi_reg == TAP_LAST)
                        state_next = ST_R_MUL1;
                    else
                    begin
                        mi_next    = mi_reg + 4'd1;
                        state_next = ST_M_NEXT;
                    end
                end
            end
            ST_R_MUL1:
            begin
                ab_next    = acca_reg * accb_reg;
                cc_next    = c_sq[47:0];
                s_next     = 25'(acca_reg) + 25'(accb_reg);
                state_next = ST_R_MUL2;
            end
            ST_R_MUL2:
            begin
                det_next   = $signed({2'b00, ab_reg}) - $signed({2'b00, cc_reg});
                t_next     = s_reg * s_reg;
                state_next = ST_R_MUL3;
            end
            ST_R_MUL3:
            begin
                ph_next    = t_reg[49:24] * k_reg;
                pl_next    = t_reg[23:0] * k_reg;
                state_next = ST_R_FIN;
            end
            ST_R_FIN:
            begin
                kt_next    = kt_full[FW-1:K_FRAC_BITS];
                state_next = ST_R_SUB;
            end
            ST_R_SUB:
            begin
                r_next     = RW'(det_reg) - $signed(kt_reg);
                state_next = ST_R_END;
            end
            ST_R_END:
            begin
                if (first_reg)
                begin
                    r0_next     = r_reg;
                    first_next  = 1'b0;
                    corner_next = (r_reg > level_s);
                    ni_next     = '0;
                    state_next  = (r_reg > level_s) ? ST_N_SEL : ST_OUT;
                end
                else if (r_reg > r0_reg)
                begin
                    corner_next = 1'b0;
                    state_next  = ST_OUT;
                end
                else if (ni_reg == TAP_LAST)
                    state_next = ST_OUT;
                else
                begin
                    ni_next    = ni_reg + 4'd1;
                    state_next = ST_N_SEL;
                end
            end
            ST_OUT:
            begin
                if (res_acc)
                begin
                    if (res_last)
                    begin
                        in_pos_next  = '0;
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_pos_next = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end
                    else
                    begin
                        out_pos_next = out_pos_reg + PW'(1);
                        if (GW'(out_col_reg) == w_use - GW'(1))
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + 12'd1;
                        end
                        else
                            out_col_next = out_col_reg + XW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
                begin
                    if (cfg_index == REG_FRAME_WIDTH)
                        width_cfg_next = cfg_data[11:0];
                    else
                        height_cfg_next = cfg_data[11:0];
                    in_pos_next  = '0;
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_pos_next = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                REG_THRESHOLD: thr_next = cfg_data;
                REG_K_COEFF:   k_next   = cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            thr_reg        <= THRESHOLD_RESET;
            k_reg          <= K_RESET;
            in_pos_reg     <= '0;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_pos_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            ni_reg         <= '0;
            mi_reg         <= '0;
            ti_reg         <= '0;
            first_reg      <= 1'b0;
            ctx_reg        <= 1'b0;
            corner_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            thr_reg        <= thr_next;
            k_reg          <= k_next;
            in_pos_reg     <= in_pos_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_pos_reg    <= out_pos_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            ni_reg         <= ni_next;
            mi_reg         <= mi_next;
            ti_reg         <= ti_next;
            first_reg      <= first_next;
            ctx_reg        <= ctx_next;
            corner_reg     <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qy_reg   <= qy_next;
        qx_reg   <= qx_next;
        cpix_reg <= cpix_next;
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        pc_reg   <= pc_next;
        cena_reg <= cena_next;
        cenb_reg <= cenb_next;
        cenc_reg <= cenc_next;
        acca_reg <= acca_next;
        accb_reg <= accb_next;
        accc_reg <= accc_next;
        ab_reg   <= ab_next;
        cc_reg   <= cc_next;
        s_reg    <= s_next;
        det_reg  <= det_next;
        t_reg    <= t_next;
        ph_reg   <= ph_next;
        pl_reg   <= pl_next;
        kt_reg   <= kt_next;
        r_reg    <= r_next;
        r0_reg   <= r0_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && pix_ready))
        else $error("result pending while accepting pixels");

    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_pos_reg <= in_pos_reg)
        else $error("output position ahead of input position");

    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (res_acc && res_data.last) |=> (out_pos_reg == '0 && in_pos_reg == '0))
        else $error("frame did not restart after last transaction");

    a_emit_due: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> (out_pos_reg < total))
        else $error("result beyond frame end");

endmodule
`default_nettype wire

// File: sim/hcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcd_checker
// Watches the pixel, result and register channels of the Harris corner
// detector, keeps its own copy of line memory and geometry, predicts the corner
// flag of each position and compares every result transaction in order.
// ----------------------------------------------------------------------------
module hcd_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    input  logic          pix_ready,
    input  hcd_pkg::pix_t pix_data,
    input  logic          res_valid,
    input  logic          res_ready,
    input  hcd_pkg::res_t res_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [39:0]   cfg_data,
    output int            fail_count,
    output int            pending,
    output int            result_count,
    output int            corner_count
);
    import hcd_pkg::*;

    localparam int   LINE_LEN   = 2048;
    localparam int   KF         = 16;

    logic [7:0]  line_mem [0:7][0:LINE_LEN-1];
    int unsigned rx_pos;
    int unsigned tx_pos;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [39:0] thresh_reg;
    logic [15:0] k_reg;
    int          eff_w;
    int          eff_h;
    res_t        flag_q [$];

    initial fail_count = 0;

    task automatic report(input string msg);
        if (fail_count < 40)
            $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    function automatic void set_geometry();
        eff_w = (width_reg < 3) ? 3 : (width_reg > LINE_LEN) ? LINE_LEN : width_reg;
        eff_h = (height_reg < 3) ? 3 : height_reg;
    endfunction

    function automatic bit in_frame(input int y, input int x);
        return y >= 0 && y < eff_h && x >= 0 && x < eff_w;
    endfunction

    function automatic int pix_at(input int y, input int x);
        return line_mem[y & 7][x % LINE_LEN];
    endfunction

    function automatic void grad_products(input int y, input int x,
                                          output longint a, output longint b,
                                          output longint c);
        int ctr, gx, gy, p;
        ctr = pix_at(y, x);
        gx = 0;
        gy = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
            begin
                p = in_frame(y + dy, x + dx) ? pix_at(y + dy, x + dx) : ctr;
                gx += dx * p;
                gy += dy * p;
            end
        a = longint'(gx) * gx;
        b = longint'(gy) * gy;
        c = longint'(gx) * gy;
    endfunction

    function automatic longint harris_resp(input int y, input int x);
        longint ca, cb, cc, a, b, c, sa, sb, sc, w;
        logic [63:0] s, t, kt, kk;
        grad_products(y, x, ca, cb, cc);
        sa = 0;
        sb = 0;
        sc = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
            begin
                a = ca;
                b = cb;
                c = cc;
                w = (dy == 0 ? 2 : 1) * (dx == 0 ? 2 : 1);
                if (in_frame(y + dy, x + dx))
                    grad_products(y + dy, x + dx, a, b, c);
                sa += w * a;
                sb += w * b;
                sc += w * c;
            end
        s  = sa + sb;
        t  = s * s;
        kk = {48'd0, k_reg};
        kt = (t >> KF) * kk + (((t & ((64'd1 << KF) - 1)) * kk) >> KF);
        return sa * sb - sc * sc - longint'(kt);
    endfunction

    function automatic void take_pixel(input pix_t item);
        int unsigned total;
        int          y, x;
        longint      r0, level;
        bit          hit;
        res_t        e;
        total = eff_w * eff_h;
        if (item.mode == MODE_PIXEL && rx_pos < total)
        begin
            line_mem[(rx_pos / eff_w) & 7][rx_pos % eff_w] = item.pixel;
            rx_pos++;
        end
        if (tx_pos >= total)
            return;
        if (!(rx_pos == total || rx_pos >= tx_pos + 3 * eff_w + 4))
            return;
        y = tx_pos / eff_w;
        x = tx_pos % eff_w;
        r0 = harris_resp(y, x);
        level = longint'({24'd0, thresh_reg}) * 256 + 255;
        hit = r0 > level;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (hit && (dy != 0 || dx != 0) && in_frame(y + dy, x + dx)
                    && harris_resp(y + dy, x + dx) > r0)
                    hit = 0;
        tx_pos++;
        e.corner = hit;
        e.col    = x[10:0];
        e.row    = y[11:0];
        e.last   = (tx_pos == total);
        if (e.last)
        begin
            rx_pos = 0;
            tx_pos = 0;
        end
        flag_q.push_back(e);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            rx_pos       = 0;
            tx_pos       = 0;
            width_reg    = WIDTH_RESET;
            height_reg   = HEIGHT_RESET;
            thresh_reg   = THRESHOLD_RESET;
            k_reg        = K_RESET;
            result_count = 0;
            corner_count = 0;
            set_geometry();
            flag_q.delete();
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                result_count++;
                if (flag_q.size() == 0)
                    report($sformatf("result with none expected: row %0d col %0d",
                                     res_data.row, res_data.col));
                else
                begin
                    e = flag_q.pop_front();
                    if (e.corner)
                        corner_count++;
                    if (res_data.corner !== e.corner)
                        report($sformatf("corner %0b, expected %0b at row %0d col %0d",
                                         res_data.corner, e.corner, e.row, e.col));
                    if (res_data.col !== e.col)
                        report($sformatf("col %0d, expected %0d", res_data.col, e.col));
                    if (res_data.row !== e.row)
                        report($sformatf("row %0d, expected %0d", res_data.row, e.row));
                    if (res_data.last !== e.last)
                        report($sformatf("last %0b, expected %0b at row %0d col %0d",
                                         res_data.last, e.last, e.row, e.col));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        width_reg = cfg_data[11:0];
                        rx_pos = 0;
                        tx_pos = 0;
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg_data[11:0];
                        rx_pos = 0;
                        tx_pos = 0;
                    end
                    REG_THRESHOLD: thresh_reg = cfg_data;
                    REG_K_COEFF:   k_reg = cfg_data[15:0];
                    default: ;
                endcase
                set_geometry();
            end
            if (pix_valid && pix_ready)
                take_pixel(pix_data);
            pending <= flag_q.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Harris corner detector testbench: streams small frames of patterned and
// random pixels under many geometry, threshold and k settings, with bursty
// input, random output stalls and one long output hold; hcd_checker predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
    import hcd_pkg::*;

    localparam int   ITEM_GOAL  = 1650;
    localparam int   DRAIN_GAP  = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_ready;
    pix_t        pix_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_t        res_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [39:0] cfg_data = '0;

    int fail_count, pending, result_count, corner_count;
    int item_count = 0;
    int burst_left = 0;
    int frame_count = 0;
    bit hold_req = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    harris_corner_detector_unit dut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
        .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hcd_checker chk (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
        .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .result_count(result_count), .corner_count(corner_count)
    );

    initial
    begin
        #400_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("tb NOT OK");
        $finish;
    end

    // receiver: random stall pattern, one long hold on request
    initial
    begin
        int style, len;
        forever
        begin
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                style = $urandom_range(0, 3);
                len = $urandom_range(5, 60);
                repeat (len)
                begin
                    case (style)
                        0: res_ready <= 1'b1;
                        1: res_ready <= ($urandom_range(0, 3) != 0);
                        2: res_ready <= ($urandom_range(0, 3) == 0);
                        default: res_ready <= $urandom_range(0, 1);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_item(input logic mode, input logic [7:0] pixel);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(40, 80);
            end
            else
            begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 20);
            end
            if (gap > 0)
            begin
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix_valid <= 1'b1;
        pix_data  <= '{mode: mode, pixel: pixel};
        do @(posedge clk); while (!pix_ready);
        item_count++;
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [39:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_pixel(input int pat, input int x, input int y,
                                              input int w, input int h,
                                              input logic [7:0] base);
        case (pat)
            0: return base;
            1: return (x >= w / 2 && y >= h / 2) ? 8'd255 : 8'd0;
            2: return ((x + y) % 2) ? base : ~base;
            3: return (x == w / 2 || y == h / 2) ? 8'd255 : base;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic run_frame(input int w, input int h, input int pat, input bit noisy);
        int total, emitted, x, y;
        logic [7:0] base;
        total = w * h;
        base = 8'($urandom);
        for (int i = 0; i < total; i++)
        begin
            if (noisy && $urandom_range(0, 24) == 0)
                send_item(MODE_FLUSH, 8'($urandom));
            x = i % w;
            y = i / w;
            send_item(MODE_PIXEL, pick_pixel(pat, x, y, w, h, base));
        end
        emitted = total - 3 * w - 3;
        if (emitted < 1)
            emitted = 1;
        for (int i = 0; i < total - emitted; i++)
        begin
            if (noisy && $urandom_range(0, 3) == 0)
                send_item(MODE_PIXEL, 8'($urandom));
            else
                send_item(MODE_FLUSH, 8'($urandom));
        end
        frame_count++;
    endtask

    initial
    begin
        int w, h;
        logic [39:0] thr;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        // directed: smallest frame, zero threshold and k, early flush first
        write_reg(REG_THRESHOLD, 40'd0);
        write_reg(REG_K_COEFF, 40'd0);
        write_reg(REG_FRAME_WIDTH, 40'd0);
        write_reg(REG_FRAME_HEIGHT, 40'd2);
        send_item(MODE_FLUSH, 8'hFF);
        run_frame(3, 3, 1, 1);
        settle();

        // widest geometry, cut short by a geometry change
        write_reg(REG_THRESHOLD, 40'hFF_FFFF_FFFF);
        write_reg(REG_K_COEFF, 40'hFFFF);
        write_reg(REG_FRAME_WIDTH, 40'd4095);
        write_reg(REG_FRAME_HEIGHT, 40'd3);
        for (int i = 0; i < 10; i++)
            send_item(MODE_PIXEL, (i % 2) ? 8'hFF : 8'h00);
        settle();

        // tallest geometry, cut short after a few results
        write_reg(REG_FRAME_WIDTH, 40'd3);
        write_reg(REG_FRAME_HEIGHT, 40'd4095);
        for (int i = 0; i < 20; i++)
            send_item(MODE_PIXEL, 8'($urandom));
        settle();

        write_reg(REG_THRESHOLD, 40'd1000);
        write_reg(REG_K_COEFF, 40'd3932);
        write_reg(REG_FRAME_WIDTH, 40'd5);
        write_reg(REG_FRAME_HEIGHT, 40'd4);
        run_frame(5, 4, 3, 0);
        settle();

        while (item_count < ITEM_GOAL)
        begin
            if ($urandom_range(0, 7) == 0)
                w = $urandom_range(9, 24);
            else
                w = $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            case ($urandom_range(0, 7))
                0, 1: thr = (w * h <= 30) ? 40'($urandom_range(0, 4095))
                                          : {$urandom, 8'h0};
                2, 3, 4: thr = {8'($urandom), 32'($urandom)} >> $urandom_range(0, 20);
                5: thr = 40'($urandom) << $urandom_range(0, 8);
                default: thr = 40'hFF_FFFF_FFFF;
            endcase
            if ($urandom_range(0, 3) != 0 || thr < 40'd4096)
                write_reg(REG_THRESHOLD, thr);
            if ($urandom_range(0, 1))
                case ($urandom_range(0, 3))
                    0: write_reg(REG_K_COEFF, 40'd0);
                    1: write_reg(REG_K_COEFF, 40'hFFFF);
                    default: write_reg(REG_K_COEFF, 40'($urandom_range(0, 65535)));
                endcase
            write_reg(REG_FRAME_WIDTH, 40'(w));
            write_reg(REG_FRAME_HEIGHT, 40'(h));
            if (frame_count == 6)
                hold_req = 1;
            run_frame(w, h, $urandom_range(0, 4), $urandom_range(0, 1));
            settle();
        end

        settle();
        $display("%0d transactions in %0d frames, %0d results checked, %0d corners",
                 item_count, frame_count, result_count, corner_count);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/hcd_pkg.sv
rtl/harris_corner_detector_unit.sv
sim/hcd_checker.sv
sim/tb.sv
